### hdl/msc_pkg.sv
package msc_pkg;

  localparam int unsigned DmemWordsDef = 1024;
  localparam int unsigned NumRegsDef   = 32;
  localparam logic [31:0] GpInit       = 32'h1000_8000;
  localparam logic [31:0] DmemBase     = 32'h1000_0000;
  localparam logic [31:0] PcHighMask   = 32'hf000_0000;
  localparam logic [31:0] StartPcRst   = 32'h0040_0000;

  // primary opcodes
  localparam logic [5:0] OpSpecial = 6'h00;
  localparam logic [5:0] OpJ       = 6'h02;
  localparam logic [5:0] OpJal     = 6'h03;
  localparam logic [5:0] OpBeq     = 6'h04;
  localparam logic [5:0] OpBne     = 6'h05;
  localparam logic [5:0] OpAddiu   = 6'h09;
  localparam logic [5:0] OpAndi    = 6'h0c;
  localparam logic [5:0] OpLui     = 6'h0f;
  localparam logic [5:0] OpTrap    = 6'h1a;
  localparam logic [5:0] OpLw      = 6'h23;
  localparam logic [5:0] OpSw      = 6'h2b;

  // special function codes
  localparam logic [5:0] FnSll  = 6'h00;
  localparam logic [5:0] FnSra  = 6'h03;
  localparam logic [5:0] FnJr   = 6'h08;
  localparam logic [5:0] FnMfhi = 6'h10;
  localparam logic [5:0] FnMflo = 6'h12;
  localparam logic [5:0] FnMult = 6'h18;
  localparam logic [5:0] FnDiv  = 6'h1a;
  localparam logic [5:0] FnAddu = 6'h21;
  localparam logic [5:0] FnSubu = 6'h23;
  localparam logic [5:0] FnSlt  = 6'h2a;

  // trap codes
  localparam logic [3:0] TrNewline = 4'h0;
  localparam logic [3:0] TrPrint   = 4'h1;
  localparam logic [3:0] TrRead    = 4'h5;

  // console events
  localparam logic [1:0] EvNone    = 2'd0;
  localparam logic [1:0] EvNewline = 2'd1;
  localparam logic [1:0] EvPrint   = 2'd2;
  localparam logic [1:0] EvRead    = 2'd3;

  // divider request and response
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [31:0] rem;
  } div_rsp_t;

endpackage

### hdl/msc_ram.sv
module msc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/msc_div.sv
module msc_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  msc_pkg::div_req_t req_i,
  output msc_pkg::div_rsp_t rsp_o
);
  import msc_pkg::*;

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic        done_q, done_d;
  logic [32:0] trial;

  // restoring unsigned divide, one quotient bit a cycle
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[31]} - {1'b0, dvs_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

### hdl/mips_subset_core_step_core.sv
// sequence: StReadRs, StReadRt, StExec, StWrite, StOut; lw adds StLoad, mult
// StMulWait and StMult, div StDiv (restoring divider) unless dividing by zero;
// a core already halted goes from StExec to StOut; one instruction at a time: a
// new request can be taken from the cycle after the result is taken
// reset: after rst_ni a pass writes the register file (zero, but gp and sp get
// their initial values) and then the data memory (zero) before the first request
module mips_subset_core_step_core #(
  parameter int unsigned DMEM_WORDS = msc_pkg::DmemWordsDef,
  parameter int unsigned NUM_REGS   = msc_pkg::NumRegsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write: start_pc
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  // request: [31:0] instr_word, [63:32] console_value
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  // result: [31:0] next_pc, [32] reg_written, [37:33] dest_index,
  // [69:38] dest_value, [71:70] console_event, [103:72] print_value,
  // [104] halted, [105] unimplemented, [111:106] zero
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata
);
  import msc_pkg::*;

  localparam int unsigned AW = $clog2(DMEM_WORDS);
  localparam int unsigned RW = $clog2(NUM_REGS);
  localparam logic [31:0] SpInit = DmemBase + 32'(4 * DMEM_WORDS);

  typedef enum logic [3:0] {
    StClrReg, StClrMem, StIdle, StReadRs, StReadRt, StExec, StMulWait, StMult,
    StDiv, StLoad, StWrite, StOut
  } state_e;

  state_e      state_q;
  logic [31:0] pc_q, hi_q, lo_q, ins_q, cval_q, vs_q, vt_q;
  logic        halt_q;
  logic [AW:0] clr_q;
  logic [63:0] prod_q;
  logic        neg_q, rneg_q;
  logic [31:0] ma_q, mb_q;
  logic        vt_loaded_q;

  // result holding register
  logic        ov_q;
  logic [31:0] o_npc_q, o_val_q, o_pval_q;
  logic        o_wr_q, o_halt_q, o_unimpl_q;
  logic [4:0]  o_dst_q;
  logic [1:0]  o_ev_q;

  // memory ports
  logic          rf_we, dm_we;
  logic [RW-1:0] rf_wa, rf_ra;
  logic [31:0]   rf_wd, rf_rd, dm_wd, dm_rd;
  logic [AW-1:0] dm_wa, dm_ra;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // instruction fields
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [31:0] uimm, simm, pc4, jtgt, addr, woff;
  logic        in_mem;

  assign op   = ins_q[31:26];
  assign rs   = ins_q[25:21];
  assign rt   = ins_q[20:16];
  assign rd   = ins_q[15:11];
  assign sh   = ins_q[10:6];
  assign fn   = ins_q[5:0];
  assign uimm = {16'h0, ins_q[15:0]};
  assign simm = {{16{ins_q[15]}}, ins_q[15:0]};
  assign pc4  = pc_q + 32'd4;
  assign jtgt = (pc4 & PcHighMask) | {4'h0, ins_q[25:0], 2'b00};
  assign addr = vs_q + simm;
  assign woff = (addr - DmemBase) >> 2;
  assign in_mem = woff < 32'(DMEM_WORDS);

  msc_ram #(.Width(32), .Depth(NUM_REGS)) u_rf (
    .clk_i, .we_i(rf_we), .waddr_i(rf_wa), .wdata_i(rf_wd),
    .raddr_i(rf_ra), .rdata_o(rf_rd)
  );

  msc_ram #(.Width(32), .Depth(DMEM_WORDS)) u_dm (
    .clk_i, .we_i(dm_we), .waddr_i(dm_wa), .wdata_i(dm_wd),
    .raddr_i(dm_ra), .rdata_o(dm_rd)
  );

  msc_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // execute: write value and next pc
  logic        x_wr, x_unimpl, x_halt, x_mul, x_div, x_ld;
  logic [4:0]  x_dst;
  logic [31:0] x_val, x_npc, x_pval;
  logic [1:0]  x_ev;

  always_comb begin
    x_wr = 1'b0; x_unimpl = 1'b0; x_halt = 1'b0; x_mul = 1'b0; x_div = 1'b0;
    x_ld = 1'b0; x_dst = '0; x_val = '0; x_npc = pc4; x_pval = '0; x_ev = EvNone;
    unique case (op)
      OpSpecial: begin
        unique case (fn)
          FnSll:  begin x_wr = 1'b1; x_dst = rd; x_val = vt_q << sh; end
          FnSra:  begin x_wr = 1'b1; x_dst = rd; x_val = $signed(vt_q) >>> sh; end
          FnJr:   x_npc = vs_q;
          FnMfhi: begin x_wr = 1'b1; x_dst = rd; x_val = hi_q; end
          FnMflo: begin x_wr = 1'b1; x_dst = rd; x_val = lo_q; end
          FnMult: x_mul = 1'b1;
          FnDiv:  x_div = (vt_q != 32'd0);
          FnAddu: begin x_wr = 1'b1; x_dst = rd; x_val = vs_q + vt_q; end
          FnSubu: begin x_wr = 1'b1; x_dst = rd; x_val = vs_q - vt_q; end
          FnSlt:  begin
            x_wr = 1'b1; x_dst = rd;
            x_val = {31'h0, $signed(vs_q) < $signed(vt_q)};
          end
          default: x_unimpl = 1'b1;
        endcase
      end
      OpJ:     x_npc = jtgt;
      OpJal:   begin x_wr = 1'b1; x_dst = 5'd31; x_val = pc4; x_npc = jtgt; end
      OpBeq:   if (vs_q == vt_q) x_npc = pc4 + {simm[29:0], 2'b00};
      OpBne:   if (vs_q != vt_q) x_npc = pc4 + {simm[29:0], 2'b00};
      OpAddiu: begin x_wr = 1'b1; x_dst = rt; x_val = vs_q + simm; end
      OpAndi:  begin x_wr = 1'b1; x_dst = rt; x_val = vs_q & uimm; end
      OpLui:   begin x_wr = 1'b1; x_dst = rt; x_val = {ins_q[15:0], 16'h0}; end
      OpTrap: begin
        unique case (ins_q[3:0])
          TrNewline: x_ev = EvNewline;
          TrPrint:   begin x_ev = EvPrint; x_pval = vs_q; end
          TrRead:    begin x_ev = EvRead; x_wr = 1'b1; x_dst = rt; x_val = cval_q; end
          default:   x_halt = 1'b1;
        endcase
      end
      OpLw:    begin x_wr = 1'b1; x_dst = rt; x_ld = in_mem; end
      OpSw:    ;
      default: x_unimpl = 1'b1;
    endcase
  end

  logic [63:0] prod_n;
  assign prod_n = neg_q ? (64'd0 - prod_q) : prod_q;

  // memory port muxing
  always_comb begin
    rf_we = 1'b0; rf_wa = '0; rf_wd = '0; rf_ra = rs[RW-1:0];
    dm_we = 1'b0; dm_wa = woff[AW-1:0]; dm_wd = vt_q; dm_ra = woff[AW-1:0];
    if (state_q == StClrReg) begin
      rf_we = 1'b1; rf_wa = clr_q[RW-1:0];
      rf_wd = (clr_q[RW-1:0] == RW'(28)) ? GpInit :
              (clr_q[RW-1:0] == RW'(29)) ? SpInit : 32'h0;
    end else if (state_q == StClrMem) begin
      dm_we = 1'b1; dm_wa = clr_q[AW-1:0]; dm_wd = '0;
    end else if (state_q == StReadRt) begin
      rf_ra = rt[RW-1:0];
    end else if (state_q == StWrite) begin
      rf_we = o_wr_q; rf_wa = o_dst_q[RW-1:0]; rf_wd = o_val_q;
    end else if (state_q == StExec) begin
      dm_we = vt_loaded_q && !halt_q && (op == OpSw) && in_mem;
    end
  end

  assign div_req.start    = (state_q == StExec) && vt_loaded_q && !halt_q && x_div;
  assign div_req.dividend = vs_q[31] ? (32'd0 - vs_q) : vs_q;
  assign div_req.divisor  = vt_q[31] ? (32'd0 - vt_q) : vt_q;

  assign cfg_ready_o   = (state_q == StIdle);
  assign s_axis_tready = (state_q == StIdle) && !ov_q && !cfg_valid_i;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClrReg;
      clr_q      <= '0;
      pc_q       <= StartPcRst;
      hi_q       <= '0;
      lo_q       <= '0;
      halt_q     <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) ov_q <= 1'b0;
      unique case (state_q)
        StClrReg: begin
          if (clr_q == (AW+1)'(NUM_REGS - 1)) begin
            clr_q <= '0; state_q <= StClrMem;
          end else begin
            clr_q <= clr_q + (AW+1)'(1);
          end
        end
        StClrMem: begin
          clr_q <= clr_q + (AW+1)'(1);
          if (clr_q == (AW+1)'(DMEM_WORDS - 1)) state_q <= StIdle;
        end
        StIdle: begin
          if (cfg_valid_i) begin
            pc_q <= cfg_data_i;
          end else if (s_axis_tvalid && !ov_q) begin
            ins_q <= s_axis_tdata[31:0]; cval_q <= s_axis_tdata[63:32];
            state_q <= StReadRs;
          end
        end
        StReadRs: state_q <= StReadRt;
        StReadRt: begin
          vs_q <= (rs == 5'd0) ? 32'h0 : rf_rd;
          state_q <= StExec;
        end
        StExec: begin
          if (!vt_loaded_q) begin
            // rt value arrives from the read port
            vt_q <= (rt == 5'd0) ? 32'h0 : rf_rd;
          end else if (halt_q) begin
            o_npc_q <= pc_q; o_wr_q <= 1'b0; o_dst_q <= '0; o_val_q <= '0;
            o_ev_q <= EvNone; o_pval_q <= '0; o_halt_q <= 1'b1; o_unimpl_q <= 1'b0;
            state_q <= StOut;
          end else begin
            pc_q <= x_npc; o_npc_q <= x_npc;
            o_wr_q <= x_wr && (x_dst != 5'd0);
            o_dst_q <= (x_wr && x_dst != 5'd0) ? x_dst : 5'd0;
            o_val_q <= (x_wr && x_dst != 5'd0) ? x_val : 32'h0;
            o_ev_q <= x_ev; o_pval_q <= x_pval; o_unimpl_q <= x_unimpl;
            halt_q <= x_halt; o_halt_q <= x_halt;
            neg_q  <= vs_q[31] ^ vt_q[31];
            rneg_q <= vs_q[31];
            if (x_mul) state_q <= StMulWait;
            else if (x_div) state_q <= StDiv;
            else if (x_ld) state_q <= StLoad;
            else state_q <= StWrite;
          end
        end
        StMulWait: state_q <= StMult;
        StMult: begin
          hi_q <= prod_n[63:32]; lo_q <= prod_n[31:0]; state_q <= StWrite;
        end
        StDiv: if (div_rsp.done) begin
          lo_q <= neg_q ? (32'd0 - div_rsp.quot) : div_rsp.quot;
          hi_q <= rneg_q ? (32'd0 - div_rsp.rem) : div_rsp.rem;
          state_q <= StWrite;
        end
        StLoad: begin
          if (o_wr_q) o_val_q <= dm_rd;
          state_q <= StWrite;
        end
        StWrite: begin
          if (o_wr_q && o_dst_q == 5'd0) begin
            o_wr_q <= 1'b0; o_val_q <= '0;
          end
          state_q <= StOut;
        end
        StOut: begin ov_q <= 1'b1; state_q <= StIdle; end
        default: state_q <= StIdle;
      endcase
    end
  end

  // vt arrives in the cycle after entering execute
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vt_loaded_q <= 1'b0;
    else vt_loaded_q <= (state_q == StExec) && !vt_loaded_q;
  end

  // magnitude product, one 32x32 multiply registered
  always_ff @(posedge clk_i) begin
    ma_q   <= vs_q[31] ? (32'd0 - vs_q) : vs_q;
    mb_q   <= vt_q[31] ? (32'd0 - vt_q) : vt_q;
    prod_q <= {32'h0, ma_q} * {32'h0, mb_q};
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {6'h0, o_unimpl_q, o_halt_q, o_pval_q, o_ev_q, o_val_q,
                          o_dst_q, o_wr_q, o_npc_q};

`ifndef ASSERT_OFF
  a_no_req_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (state_q == StIdle)) else $error("request taken while busy");
  a_r0_never: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(o_wr_q && o_dst_q == 5'd0)) else $error("r0 reported written");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(halt_q) && !$past(cfg_valid_i && cfg_ready_o) |-> halt_q)
    else $error("halt flag cleared");
`endif

endmodule

### tb/sv/tb_mips_subset_core_step_core.sv
module tb_mips_subset_core_step_core;
  import msc_pkg::*;

  localparam int unsigned DmemWords = DmemWordsDef;
  localparam int unsigned IdleLimit = 20000;

  // one step result, laid out as on m_axis_tdata
  typedef struct packed {
    logic [5:0]  pad;
    logic        unimpl;
    logic        halted;
    logic [31:0] print_value;
    logic [1:0]  console_event;
    logic [31:0] dest_value;
    logic [4:0]  dest_index;
    logic        reg_written;
    logic [31:0] next_pc;
  } step_res_t;

  typedef struct {
    logic [31:0] ins;
    logic [31:0] cval;
    bit          typed;
    step_res_t   res;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;

  // core model state
  logic [31:0] core_pc;
  logic [31:0] core_regs [32];
  logic [31:0] core_hi, core_lo;
  logic        core_halt;
  logic [31:0] core_mem [DmemWords];

  step_res_t pending_steps[$];
  int        mismatches = 0;
  int        steps_sent = 0;
  int        steps_seen = 0;
  int        burst_left = 0;
  int        idle_cycles = 0;

  mips_subset_core_step_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // instruction encoders
  function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                        logic [4:0] sh, logic [5:0] fn);
    return {OpSpecial, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] enc_j(logic [5:0] op, logic [25:0] tgt);
    return {op, tgt};
  endfunction

  function automatic step_res_t mk_res(logic [31:0] npc, logic wr, logic [4:0] idx,
                                       logic [31:0] val, logic [1:0] ev, logic [31:0] pv,
                                       logic un);
    step_res_t r;
    r = '0;
    r.next_pc = npc;
    r.reg_written = wr;
    r.dest_index = idx;
    r.dest_value = val;
    r.console_event = ev;
    r.print_value = pv;
    r.unimpl = un;
    return r;
  endfunction

  task automatic core_reset();
    core_pc = StartPcRst;
    foreach (core_regs[i]) core_regs[i] = '0;
    core_regs[28] = GpInit;
    core_regs[29] = DmemBase + 4 * DmemWords;
    core_hi = '0;
    core_lo = '0;
    core_halt = 1'b0;
    foreach (core_mem[i]) core_mem[i] = '0;
  endtask

  // executes one instruction on the model state and returns its result
  function automatic step_res_t execute_step(logic [31:0] ins, logic [31:0] cval);
    step_res_t   r;
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [31:0] uimm, simm, vs, vt, pc4, npc, val, pval, word;
    logic [4:0]  dst;
    logic [1:0]  ev;
    logic        wr, un;
    logic [63:0] prod;
    longint      q, rm;
    r = '0;
    if (core_halt) begin
      r.next_pc = core_pc;
      r.halted = 1'b1;
      return r;
    end
    op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11];
    sh = ins[10:6]; fn = ins[5:0];
    uimm = {16'h0, ins[15:0]};
    simm = {{16{ins[15]}}, ins[15:0]};
    vs = core_regs[rs];
    vt = core_regs[rt];
    pc4 = core_pc + 32'd4;
    npc = pc4;
    wr = 1'b0; un = 1'b0; dst = '0; val = '0; ev = EvNone; pval = '0;
    case (op)
      OpSpecial: begin
        case (fn)
          FnSll:  begin wr = 1; dst = rd; val = vt << sh; end
          FnSra:  begin wr = 1; dst = rd; val = $signed(vt) >>> sh; end
          FnJr:   npc = vs;
          FnMfhi: begin wr = 1; dst = rd; val = core_hi; end
          FnMflo: begin wr = 1; dst = rd; val = core_lo; end
          FnMult: begin
            prod = $signed({{32{vs[31]}}, vs}) * $signed({{32{vt[31]}}, vt});
            core_hi = prod[63:32];
            core_lo = prod[31:0];
          end
          FnDiv: begin
            // divide by zero leaves hi and lo alone
            if (vt != 0) begin
              q = longint'($signed(vs)) / longint'($signed(vt));
              rm = longint'($signed(vs)) % longint'($signed(vt));
              core_lo = q[31:0];
              core_hi = rm[31:0];
            end
          end
          FnAddu: begin wr = 1; dst = rd; val = vs + vt; end
          FnSubu: begin wr = 1; dst = rd; val = vs - vt; end
          FnSlt:  begin wr = 1; dst = rd; val = ($signed(vs) < $signed(vt)) ? 1 : 0; end
          default: un = 1'b1;
        endcase
      end
      OpJ:   npc = (pc4 & PcHighMask) | {4'h0, ins[25:0], 2'b00};
      OpJal: begin
        wr = 1; dst = 5'd31; val = pc4;
        npc = (pc4 & PcHighMask) | {4'h0, ins[25:0], 2'b00};
      end
      OpBeq:   if (vs == vt) npc = pc4 + (simm << 2);
      OpBne:   if (vs != vt) npc = pc4 + (simm << 2);
      OpAddiu: begin wr = 1; dst = rt; val = vs + simm; end
      OpAndi:  begin wr = 1; dst = rt; val = vs & uimm; end
      OpLui:   begin wr = 1; dst = rt; val = uimm << 16; end
      OpTrap: begin
        case (ins[3:0])
          TrNewline: ev = EvNewline;
          TrPrint:   begin ev = EvPrint; pval = vs; end
          TrRead:    begin ev = EvRead; wr = 1; dst = rt; val = cval; end
          default:   core_halt = 1'b1;
        endcase
      end
      OpLw: begin
        wr = 1; dst = rt;
        word = (vs + simm - DmemBase) >> 2;
        val = (word < DmemWords) ? core_mem[word] : 32'h0;
      end
      OpSw: begin
        word = (vs + simm - DmemBase) >> 2;
        if (word < DmemWords) core_mem[word] = vt;
      end
      default: un = 1'b1;
    endcase
    // writes to r0 vanish
    if (wr && dst != 0) core_regs[dst] = val;
    else begin wr = 0; dst = 0; val = 0; end
    core_pc = npc;
    r.next_pc = npc;
    r.reg_written = wr;
    r.dest_index = dst;
    r.dest_value = val;
    r.console_event = ev;
    r.print_value = pval;
    r.halted = core_halt;
    r.unimpl = un;
    return r;
  endfunction

  // sends one request in bursts with random gaps
  task automatic send_step(logic [31:0] ins, logic [31:0] cval, bit typed, step_res_t want);
    int        gap;
    step_res_t r;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {cval, ins};
    do @(posedge clk_i); while (!s_axis_tready);
    r = execute_step(ins, cval);
    pending_steps.push_back(typed ? want : r);
    steps_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_steps.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // start pc write, only with the core idle
  task automatic write_start_pc(logic [31:0] pc);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= pc;
    do @(posedge clk_i); while (!cfg_ready_o);
    core_pc = pc;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [4:0] pick_dest();
    logic [4:0] d;
    d = $urandom_range(0, 31);
    if (d == 29 && $urandom_range(0, 9) != 0) d = $urandom_range(8, 27);
    return d;
  endfunction

  // random instruction, mostly well formed, never a halting trap
  function automatic logic [31:0] random_instr();
    logic [31:0] w;
    logic [4:0]  rs, rt, rd;
    logic [15:0] off;
    rs = $urandom_range(0, 31);
    rt = $urandom_range(0, 31);
    rd = pick_dest();
    off = 16'(-(4 * $urandom_range(1, DmemWords)) + $urandom_range(0, 3));
    case ($urandom_range(0, 23))
      0:  w = enc_r(rs, rt, rd, 5'($urandom), FnSll);
      1:  w = enc_r(rs, rt, rd, 5'($urandom), FnSra);
      2:  w = enc_r(rs, rt, rd, 5'($urandom), FnJr);
      3:  w = enc_r(rs, rt, rd, 5'd0, FnMfhi);
      4:  w = enc_r(rs, rt, rd, 5'd0, FnMflo);
      5:  w = enc_r(rs, rt, rd, 5'd0, FnMult);
      6:  w = enc_r(rs, rt, rd, 5'd0, FnDiv);
      7:  w = enc_r(rs, rt, rd, 5'd0, FnAddu);
      8:  w = enc_r(rs, rt, rd, 5'd0, FnSubu);
      9:  w = enc_r(rs, rt, rd, 5'd0, FnSlt);
      10: w = enc_j(OpJ, 26'($urandom));
      11: w = enc_j(OpJal, 26'($urandom));
      12: w = enc_i(OpBeq, rs, $urandom_range(0, 3) == 0 ? rs : rt, 16'($urandom));
      13: w = enc_i(OpBne, rs, rt, 16'($urandom));
      14: w = enc_i(OpAddiu, rs, rd, 16'($urandom));
      15: w = enc_i(OpAndi, rs, rd, 16'($urandom));
      16: w = enc_i(OpLui, rs, rd, 16'($urandom));
      17, 18: w = enc_i(OpLw, $urandom_range(0, 3) != 0 ? 5'd29 : rs, rd,
                        $urandom_range(0, 7) != 0 ? off : 16'($urandom));
      19, 20: w = enc_i(OpSw, $urandom_range(0, 3) != 0 ? 5'd29 : rs, rt,
                        $urandom_range(0, 7) != 0 ? off : 16'($urandom));
      21: w = {OpTrap, rs, rd, 12'($urandom), TrNewline};
      22: w = {OpTrap, rs, rd, 12'($urandom), $urandom_range(0, 1) ? TrPrint : TrRead};
      default: begin
        // raw noise word
        w = $urandom;
        if (w[31:26] == OpTrap) w[3:0] = TrNewline;
      end
    endcase
    return w;
  endfunction

  // receiver stall pattern: ready, random, long stalls
  int rx_mode = 0, rx_left = 0;
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(5, 60);
    end
    rx_left--;
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      default: m_axis_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // result checker
  always @(posedge clk_i) begin
    step_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      steps_seen++;
      if (pending_steps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_steps.pop_front();
        if (got.next_pc !== want.next_pc || got.reg_written !== want.reg_written ||
            got.dest_index !== want.dest_index || got.dest_value !== want.dest_value ||
            got.console_event !== want.console_event ||
            got.print_value !== want.print_value || got.halted !== want.halted ||
            got.unimpl !== want.unimpl || got.pad !== want.pad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %h got %h", want, got);
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired with %0d results outstanding", pending_steps.size());
      $display("mips_subset_core_step_core verification failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    dir_row_t    rows[$];
    logic [31:0] phase_pc[4];
    int          halt_code;
    core_reset();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed rows, straight line code from the reset start pc
    rows = '{
      '{enc_i(OpLui, 0, 8, 16'h8000), 0, 1,
        mk_res(32'h0040_0004, 1, 8, 32'h8000_0000, EvNone, 0, 0)},
      '{enc_i(OpAddiu, 0, 9, 16'hffff), 0, 1,
        mk_res(32'h0040_0008, 1, 9, 32'hffff_ffff, EvNone, 0, 0)},
      '{enc_r(0, 9, 10, 31, FnSll), 0, 1,
        mk_res(32'h0040_000c, 1, 10, 32'h8000_0000, EvNone, 0, 0)},
      '{enc_r(0, 8, 11, 31, FnSra), 0, 1,
        mk_res(32'h0040_0010, 1, 11, 32'hffff_ffff, EvNone, 0, 0)},
      '{enc_r(8, 9, 12, 0, FnAddu), 0, 1,
        mk_res(32'h0040_0014, 1, 12, 32'h7fff_ffff, EvNone, 0, 0)},
      '{enc_r(0, 9, 13, 0, FnSubu), 0, 1,
        mk_res(32'h0040_0018, 1, 13, 32'h1, EvNone, 0, 0)},
      '{enc_r(8, 9, 14, 0, FnSlt), 0, 1,
        mk_res(32'h0040_001c, 1, 14, 32'h1, EvNone, 0, 0)},
      '{enc_i(OpAndi, 9, 15, 16'hffff), 0, 1,
        mk_res(32'h0040_0020, 1, 15, 32'h0000_ffff, EvNone, 0, 0)},
      '{enc_r(8, 9, 0, 0, FnMult), 0, 0, '0},
      '{enc_r(0, 0, 16, 0, FnMfhi), 0, 0, '0},
      '{enc_r(0, 0, 17, 0, FnMflo), 0, 0, '0},
      // divide overflow
      '{enc_r(8, 9, 0, 0, FnDiv), 0, 0, '0},
      '{enc_r(0, 0, 18, 0, FnMflo), 0, 1,
        mk_res(32'h0040_0034, 1, 18, 32'h8000_0000, EvNone, 0, 0)},
      '{enc_r(0, 0, 19, 0, FnMfhi), 0, 1,
        mk_res(32'h0040_0038, 1, 19, 0, EvNone, 0, 0)},
      // divide by zero keeps lo
      '{enc_r(9, 0, 0, 0, FnDiv), 0, 0, '0},
      '{enc_r(0, 0, 18, 0, FnMflo), 0, 1,
        mk_res(32'h0040_0040, 1, 18, 32'h8000_0000, EvNone, 0, 0)},
      // top word of memory, then just past it
      '{enc_i(OpSw, 29, 9, 16'hfffc), 0, 0, '0},
      '{enc_i(OpLw, 29, 20, 16'hfffc), 0, 1,
        mk_res(32'h0040_0048, 1, 20, 32'hffff_ffff, EvNone, 0, 0)},
      '{enc_i(OpLw, 29, 21, 16'h0000), 0, 1,
        mk_res(32'h0040_004c, 1, 21, 32'h0, EvNone, 0, 0)},
      '{enc_i(OpAddiu, 9, 0, 16'h0005), 0, 1,
        mk_res(32'h0040_0050, 0, 0, 0, EvNone, 0, 0)},
      '{{OpTrap, 26'(TrNewline)}, 0, 1,
        mk_res(32'h0040_0054, 0, 0, 0, EvNewline, 0, 0)},
      '{{OpTrap, 5'd9, 5'd0, 16'(TrPrint)}, 0, 1,
        mk_res(32'h0040_0058, 0, 0, 0, EvPrint, 32'hffff_ffff, 0)},
      '{{OpTrap, 5'd0, 5'd22, 16'(TrRead)}, 32'h8000_0000, 1,
        mk_res(32'h0040_005c, 1, 22, 32'h8000_0000, EvRead, 0, 0)},
      '{{6'h3f, 26'h3ff_ffff}, 32'hffff_ffff, 1,
        mk_res(32'h0040_0060, 0, 0, 0, EvNone, 0, 1)},
      '{enc_r(31, 31, 31, 31, 6'h3f), 0, 1,
        mk_res(32'h0040_0064, 0, 0, 0, EvNone, 0, 1)},
      '{enc_i(OpBeq, 0, 0, 16'hffff), 0, 0, '0},
      '{enc_i(OpBne, 8, 9, 16'h7fff), 0, 0, '0},
      '{enc_j(OpJ, 26'h3ff_ffff), 0, 0, '0},
      '{enc_j(OpJal, 26'h0), 0, 0, '0},
      '{enc_r(9, 0, 0, 0, FnJr), 0, 0, '0}
    };
    foreach (rows[i]) send_step(rows[i].ins, rows[i].cval, rows[i].typed, rows[i].res);

    // random phases under several start pcs
    phase_pc[0] = 32'h0000_0000;
    phase_pc[1] = 32'hffff_ffff;
    phase_pc[2] = 32'hffff_fffc;
    phase_pc[3] = $urandom;
    foreach (phase_pc[p]) begin
      write_start_pc(phase_pc[p]);
      repeat (105) send_step(random_instr(), $urandom, 0, '0);
    end

    // halt by exit or by an unknown code, then the held state
    write_start_pc(StartPcRst);
    repeat (5) send_step(random_instr(), $urandom, 0, '0);
    halt_code = $urandom_range(0, 1) ? 4'ha : 4'h7;
    send_step({OpTrap, 22'($urandom), 4'(halt_code)}, 0, 0, '0);
    repeat (6) send_step(random_instr(), $urandom, 0, '0);
    drain();
    repeat (40) @(posedge clk_i);

    $display("%0d instructions sent, %0d results checked, over five start pc settings",
             steps_sent, steps_seen);
    $display("covered all opcodes, console traps, hi/lo corner cases and halt");
    if (mismatches == 0 && pending_steps.size() == 0) begin
      $display("mips_subset_core_step_core verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_steps.size());
      $display("mips_subset_core_step_core verification failed");
    end
    $finish;
  end

endmodule
